### hdl/x86_flags_and_condition_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the x86 flags and condition unit
// Shared property shapes used by the checker; clk and arst_n come from the
// scope where a macro is used.
// ---------------------------------------------------------------------------
`ifndef X86_FLAGS_AND_CONDITION_UNIT_ASSERT_SVH
`define X86_FLAGS_AND_CONDITION_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FXC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fxc assertion failed");

// Consequent checked from the cycle after the antecedent.
`define FXC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fxc assertion failed");

`endif

### hdl/fxc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fxc_pkg
// Types and constants shared by the flags and condition unit modules.
// ---------------------------------------------------------------------------
package fxc_pkg;

	localparam int DATA_W      = 64;
	localparam int NUM_FLAGS   = 6;
	localparam int IN_TDATA_W  = 208;
	localparam int OUT_TDATA_W = 16;
	// Queue depth must be a power of two so the pointers wrap on their own.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Flag positions inside every flag vector.
	localparam int F_OF = 0;
	localparam int F_CF = 1;
	localparam int F_ZF = 2;
	localparam int F_SF = 3;
	localparam int F_PF = 4;
	localparam int F_AF = 5;
	localparam int AUX_BIT = 4;

	localparam logic [NUM_FLAGS-1:0] ALL_DEFINED   = 6'h3F;
	localparam logic [NUM_FLAGS-1:0] LOGIC_DEFINED = 6'h1F;

	typedef enum logic [2:0] {
		MODE_SUB   = 3'd0,
		MODE_ADD   = 3'd1,
		MODE_LOGIC = 3'd2,
		MODE_INVAL = 3'd3,
		MODE_EVAL  = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		CC_O  = 3'd0,
		CC_C  = 3'd1,
		CC_Z  = 3'd2,
		CC_BE = 3'd3,
		CC_S  = 3'd4,
		CC_P  = 3'd5,
		CC_L  = 3'd6,
		CC_LE = 3'd7
	} cc_kind_t;

	// What the back end does with a queued request.
	typedef enum logic [1:0] {
		OP_NOP  = 2'd0,
		OP_SUB  = 2'd1,
		OP_UPD  = 2'd2,
		OP_EVAL = 2'd3
	} op_t;

	// Operand comparisons of a subtraction, worked out ahead of time.
	typedef struct packed {
		logic ule;
		logic slt;
		logic sle;
	} cmp_t;

	typedef struct packed {
		op_t                  op;
		logic [NUM_FLAGS-1:0] fbits;
		logic [NUM_FLAGS-1:0] fdef;
		cmp_t                 cmp;
		logic [3:0]           cond_code;
	} qent_t;

	typedef struct packed {
		logic  valid;
		qent_t ent;
	} qhead_t;

	typedef struct packed {
		logic [1:0]           pad;
		logic                 cond_defined;
		logic                 cond_true;
		logic [NUM_FLAGS-1:0] defined_mask;
		logic [NUM_FLAGS-1:0] flags;
	} result_t;

endpackage
`default_nettype wire

### hdl/fxc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fxc_front
// Unpacks a request, masks it to its width and works out the new flags and
// the operand comparisons, so the back end needs no wide datapath.
// ---------------------------------------------------------------------------
module fxc_front
	import fxc_pkg::*;
(
	input  logic [IN_TDATA_W-1:0] s_tdata,
	output qent_t                 ent
);

	function automatic logic msb_at(input logic [DATA_W-1:0] v, input logic [1:0] s);
		logic m;
		case (s)
			2'd0:    m = v[7];
			2'd1:    m = v[15];
			2'd2:    m = v[31];
			default: m = v[63];
		endcase
		return m;
	endfunction

	logic [1:0]        width_sel;
	logic [DATA_W-1:0] mask, lhs, rhs, res, aux;
	logic              zf, sf, pf, af;
	logic              sub_cf, sub_of, add_cf, add_of;
	logic              eq, sa, sb, slt;

	assign width_sel = s_tdata[4:3];

	always_comb begin
		case (width_sel)
			2'd0:    mask = 64'h0000_0000_0000_00FF;
			2'd1:    mask = 64'h0000_0000_0000_FFFF;
			2'd2:    mask = 64'h0000_0000_FFFF_FFFF;
			default: mask = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
	end

	assign lhs = s_tdata[68:5]    & mask;
	assign rhs = s_tdata[132:69]  & mask;
	assign res = s_tdata[196:133] & mask;
	assign aux = lhs ^ rhs ^ res;

	assign zf = (res == '0);
	assign sf = msb_at(res, width_sel);
	assign pf = ~^res[7:0];
	assign af = aux[AUX_BIT];

	assign sub_cf = (lhs < rhs);
	assign sub_of = msb_at((lhs ^ res) & (lhs ^ rhs), width_sel);
	assign add_cf = (res < lhs);
	assign add_of = msb_at((lhs ^ res) & ~(lhs ^ rhs), width_sel);

	// Signed order: differing signs decide alone, else unsigned order holds.
	assign eq  = (lhs == rhs);
	assign sa  = msb_at(lhs, width_sel);
	assign sb  = msb_at(rhs, width_sel);
	assign slt = (sa != sb) ? sa : sub_cf;

	always_comb begin
		ent.op        = OP_NOP;
		ent.fbits     = '0;
		ent.fdef      = '0;
		ent.cmp.ule   = sub_cf | eq;
		ent.cmp.slt   = slt;
		ent.cmp.sle   = slt | eq;
		ent.cond_code = s_tdata[200:197];
		unique case (mode_t'(s_tdata[2:0]))
			MODE_SUB: begin
				ent.op    = OP_SUB;
				ent.fbits = {af, pf, sf, zf, sub_cf, sub_of};
				ent.fdef  = ALL_DEFINED;
			end
			MODE_ADD: begin
				ent.op    = OP_UPD;
				ent.fbits = {af, pf, sf, zf, add_cf, add_of};
				ent.fdef  = ALL_DEFINED;
			end
			MODE_LOGIC: begin
				ent.op    = OP_UPD;
				ent.fbits = {1'b0, pf, sf, zf, 2'b00};
				ent.fdef  = LOGIC_DEFINED;
			end
			MODE_INVAL: begin
				ent.op = OP_UPD;
			end
			MODE_EVAL: begin
				ent.op = OP_EVAL;
			end
			default: begin
				ent.op = OP_NOP;
			end
		endcase
	end

endmodule
`default_nettype wire

### hdl/fxc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fxc_queue
// Small register FIFO between the classifying front end and the back end.
// ---------------------------------------------------------------------------
module fxc_queue
	import fxc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qent_t  push_ent,
	input  logic   pop,
	output logic   full,
	output qhead_t head
);

	qent_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.ent   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_ent;
	end

endmodule
`default_nettype wire

### hdl/fxc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fxc_back
// Holds the flag state and the subtraction compare cache, applies queued
// requests in order and drives the output register.
// ---------------------------------------------------------------------------
module fxc_back
	import fxc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  qhead_t  head,
	output logic    pop,
	input  logic    m_tready,
	output logic    m_tvalid,
	output result_t result
);

	logic [NUM_FLAGS-1:0] flags_q, fdef_q, nx_flags, nx_fdef;
	logic                 cache_valid_q, nx_cache_valid;
	cmp_t                 cache_cmp_q, nx_cache_cmp;
	logic                 ctrue, cdef, sf_ne_of;
	logic                 valid_q;
	result_t              result_q;

	assign pop      = head.valid && (!valid_q || m_tready);
	assign sf_ne_of = flags_q[F_SF] ^ flags_q[F_OF];

	always_comb begin
		nx_flags       = flags_q;
		nx_fdef        = fdef_q;
		nx_cache_valid = cache_valid_q;
		nx_cache_cmp   = cache_cmp_q;
		ctrue          = 1'b0;
		cdef           = 1'b0;
		case (head.ent.op)
			OP_SUB: begin
				nx_flags       = head.ent.fbits;
				nx_fdef        = head.ent.fdef;
				nx_cache_valid = 1'b1;
				nx_cache_cmp   = head.ent.cmp;
			end
			OP_UPD: begin
				nx_flags       = head.ent.fbits;
				nx_fdef        = head.ent.fdef;
				nx_cache_valid = 1'b0;
			end
			OP_EVAL: begin
				unique case (cc_kind_t'(head.ent.cond_code[3:1]))
					CC_O: begin
						ctrue = flags_q[F_OF];
						cdef  = fdef_q[F_OF];
					end
					CC_C: begin
						ctrue = flags_q[F_CF];
						cdef  = fdef_q[F_CF];
					end
					CC_Z: begin
						ctrue = flags_q[F_ZF];
						cdef  = fdef_q[F_ZF];
					end
					CC_BE: begin
						ctrue = cache_valid_q ? cache_cmp_q.ule
						                      : (flags_q[F_CF] | flags_q[F_ZF]);
						cdef  = cache_valid_q | (fdef_q[F_CF] & fdef_q[F_ZF]);
					end
					CC_S: begin
						ctrue = flags_q[F_SF];
						cdef  = fdef_q[F_SF];
					end
					CC_P: begin
						ctrue = flags_q[F_PF];
						cdef  = fdef_q[F_PF];
					end
					CC_L: begin
						ctrue = cache_valid_q ? cache_cmp_q.slt : sf_ne_of;
						cdef  = cache_valid_q | (fdef_q[F_SF] & fdef_q[F_OF]);
					end
					CC_LE: begin
						ctrue = cache_valid_q ? cache_cmp_q.sle
						                      : (sf_ne_of | flags_q[F_ZF]);
						cdef  = cache_valid_q |
						        (fdef_q[F_SF] & fdef_q[F_OF] & fdef_q[F_ZF]);
					end
					default: begin
						ctrue = 1'b0;
						cdef  = 1'b0;
					end
				endcase
				ctrue = ctrue ^ head.ent.cond_code[0];
			end
			default: begin
				ctrue = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q       <= '0;
			fdef_q        <= '0;
			cache_valid_q <= 1'b0;
			cache_cmp_q   <= '0;
			valid_q       <= 1'b0;
		end else begin
			if (pop) begin
				flags_q       <= nx_flags;
				fdef_q        <= nx_fdef;
				cache_valid_q <= nx_cache_valid;
				cache_cmp_q   <= nx_cache_cmp;
				valid_q       <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.pad          <= '0;
			result_q.cond_defined <= cdef;
			result_q.cond_true    <= ctrue;
			result_q.defined_mask <= nx_fdef;
			result_q.flags        <= nx_flags;
		end
	end

	assign m_tvalid = valid_q;
	assign result   = result_q;

endmodule
`default_nettype wire

### hdl/x86_flags_and_condition_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// x86_flags_and_condition_unit
// x86 status flags (OF CF ZF SF PF AF) with defined bits, and evaluation of
// the sixteen x86 condition codes against them.
// ---------------------------------------------------------------------------
//
//  Channel   Dir  Bits  Carries
//  s_*       in   208   one request: flag update or condition evaluation
//  m_*       out  16    flags, defined mask and condition result per request
//
// One request enters per cycle while s_tready is high and passes the queue and the
// output register; steady throughput is one request per clock unless the output
// stalls. The front end classifies a request combinationally into a four-entry
// queue; the back end pops one entry per cycle into the output register. arst_n
// clears the flags, the defined bits, the compare cache and the queue. A stalled
// output fills the queue, and s_tready falls only once all four entries are taken.
//
module x86_flags_and_condition_unit
	import fxc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Request channel.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// s_tdata, from bit 0 up: mode[2:0], width_sel[4:3], lhs_value[68:5],
	// rhs_value[132:69], result_value[196:133], cond_code[200:197], zeros.
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// Result channel.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata, from bit 0 up: flag_of, flag_cf, flag_zf, flag_sf, flag_pf,
	// flag_af, defined_mask[11:6], cond_true[12], cond_defined[13], zeros.
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	qent_t   front_ent;
	qhead_t  q_head;
	logic    q_full, q_push, q_pop;
	result_t result;

	// A request is taken whenever the queue has a free entry; it never waits
	// on the output register directly.
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	// Front end: masking to the width, flag computation for updates, and the
	// three operand orderings (unsigned <=, signed <, signed <=) that a later
	// BE, L or LE condition needs from a subtraction.
	fxc_front u_front (
		.s_tdata (s_tdata),
		.ent     (front_ent)
	);

	fxc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_ent (front_ent),
		.pop      (q_pop),
		.full     (q_full),
		.head     (q_head)
	);

	// Back end: the only place that holds architectural state, so requests
	// see each other's effects strictly in arrival order.
	fxc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.pop      (q_pop),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.result   (result)
	);

	assign m_tdata = result;

endmodule
`default_nettype wire

### hdl/fxc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fxc_checker
// Port-level assertions for the flags and condition unit, bound to the top.
// ---------------------------------------------------------------------------
`include "x86_flags_and_condition_unit_assert.svh"

module fxc_checker
	import fxc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// A held result must not change until it is taken.
	`FXC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// An undefined flag always reads as zero.
	`FXC_ASSERT_SAME(a_undef_zero, m_tvalid, (m_tdata[5:0] & ~m_tdata[11:6]) == 6'd0)

	// Back pressure on requests only comes from a backlog of results.
	`FXC_ASSERT_SAME(a_backlog, !s_tready, m_tvalid)

	// A request taken while the output is empty shows up after the queue and the output register.
	`FXC_ASSERT_NEXT(a_latency, s_tvalid && s_tready && !m_tvalid, ##1 m_tvalid)

endmodule

bind x86_flags_and_condition_unit fxc_checker u_fxc_checker (.*);
`default_nettype wire
